>>> src/motor_command_framer_core_assert.svh
// Assertion macros used by the framer RTL top level
`ifndef MOTOR_COMMAND_FRAMER_CORE_ASSERT_SVH
`define MOTOR_COMMAND_FRAMER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clock, held off during reset
`define MCF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, held off during reset
`define MCF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/mcf_pkg.sv
// Types and constants shared by the motor command framer
package mcf_pkg;

   typedef enum logic [1:0] {
      OP_VELOCITY = 2'd0,
      OP_STOP     = 2'd1,
      OP_RESET    = 2'd2,
      OP_INIT     = 2'd3
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] mode;
      logic       left_neg;
      logic [3:0] left_d2;
      logic [3:0] left_d1;
      logic [3:0] left_d0;
      logic       right_neg;
      logic [3:0] right_d2;
      logic [3:0] right_d1;
      logic [3:0] right_d0;
   } cmd_type;

   localparam logic [7:0] ASCII_STX = 8'h02;
   localparam logic [7:0] ASCII_ETX = 8'h03;
   localparam int BYTE_INDEX_WIDTH = 5;

endpackage

>>> src/mcf_front.sv
// Front end: accepts requests, clamps speeds and splits them into decimal digits
module mcf_front #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_operation,
   input  logic signed [15:0]    req_left_speed,
   input  logic signed [15:0]    req_right_speed,
   input  logic [1:0]            req_stop_mode,
   input  logic                  pop,
   output logic                  push,
   output mcf_pkg::cmd_type      push_cmd
);
   import mcf_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   function automatic logic [9:0] clamp_mag(input logic signed [15:0] s);
      logic [15:0] abs_v;
      begin
         abs_v = s[15] ? (~s + 16'd1) : s;
         if (s > 16'sd999 || s < -16'sd999) begin
            clamp_mag = 10'd999;
         end else begin
            clamp_mag = abs_v[9:0];
         end
      end
   endfunction

   function automatic logic [3:0] hundreds(input logic [9:0] m);
      logic [15:0] prod;
      begin
         prod = {6'd0, m} * 16'd41;
         hundreds = prod[15:12];
      end
   endfunction

   function automatic logic [6:0] rem100(input logic [9:0] m, input logic [3:0] q);
      logic [9:0] h;
      logic [9:0] diff;
      begin
         h = {q, 6'd0} + {1'b0, q, 5'd0} + {4'd0, q, 2'd0};
         diff = m - h;
         rem100 = diff[6:0];
      end
   endfunction

   function automatic logic [3:0] tens(input logic [6:0] r);
      logic [13:0] prod;
      begin
         prod = {7'd0, r} * 14'd103;
         tens = prod[13:10];
      end
   endfunction

   function automatic logic [3:0] units(input logic [6:0] r, input logic [3:0] t);
      logic [6:0] t10;
      logic [6:0] diff;
      begin
         t10 = {t, 3'd0} + {2'd0, t, 1'd0};
         diff = r - t10;
         units = diff[3:0];
      end
   endfunction

   logic             accept;
   logic [CNT_W-1:0] in_flight_ff, in_flight_in;

   logic       a_valid_ff, a_valid_in;
   op_type     a_op_ff;
   logic [1:0] a_mode_ff;
   logic       a_lneg_ff, a_rneg_ff;
   logic [9:0] a_lmag_ff, a_rmag_ff;

   logic       b_valid_ff, b_valid_in;
   op_type     b_op_ff;
   logic [1:0] b_mode_ff;
   logic       b_lneg_ff, b_rneg_ff;
   logic [3:0] b_lq_ff, b_rq_ff;
   logic [6:0] b_lr_ff, b_rr_ff;

   logic [3:0] l_hund, r_hund, l_tens, r_tens;

   assign accept = start && !busy;
   assign busy   = (in_flight_ff == CNT_W'(DEPTH));

   always_comb begin
      in_flight_in = in_flight_ff;
      if (accept && !pop) begin
         in_flight_in = in_flight_ff + CNT_W'(1);
      end else if (!accept && pop) begin
         in_flight_in = in_flight_ff - CNT_W'(1);
      end
   end

   assign a_valid_in = accept;
   assign b_valid_in = a_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
      end else begin
         in_flight_ff <= in_flight_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_op_ff   <= op_type'(req_operation);
      a_mode_ff <= (req_stop_mode == 2'd0) ? 2'd1 : req_stop_mode;
      a_lneg_ff <= req_left_speed[15];
      a_rneg_ff <= req_right_speed[15];
      a_lmag_ff <= clamp_mag(req_left_speed);
      a_rmag_ff <= clamp_mag(req_right_speed);
   end

   assign l_hund = hundreds(a_lmag_ff);
   assign r_hund = hundreds(a_rmag_ff);

   always_ff @(posedge clock) begin
      b_op_ff   <= a_op_ff;
      b_mode_ff <= a_mode_ff;
      b_lneg_ff <= a_lneg_ff;
      b_rneg_ff <= a_rneg_ff;
      b_lq_ff   <= l_hund;
      b_rq_ff   <= r_hund;
      b_lr_ff   <= rem100(a_lmag_ff, l_hund);
      b_rr_ff   <= rem100(a_rmag_ff, r_hund);
   end

   assign l_tens = tens(b_lr_ff);
   assign r_tens = tens(b_rr_ff);

   assign push = b_valid_ff;

   always_comb begin
      push_cmd.op        = b_op_ff;
      push_cmd.mode      = b_mode_ff;
      push_cmd.left_neg  = b_lneg_ff;
      push_cmd.left_d2   = b_lq_ff;
      push_cmd.left_d1   = l_tens;
      push_cmd.left_d0   = units(b_lr_ff, l_tens);
      push_cmd.right_neg = b_rneg_ff;
      push_cmd.right_d2  = b_rq_ff;
      push_cmd.right_d1  = r_tens;
      push_cmd.right_d0  = units(b_rr_ff, r_tens);
   end

endmodule

>>> src/mcf_queue.sv
// Command queue between the front end and the byte sequencer
module mcf_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mcf_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             not_empty,
   output mcf_pkg::cmd_type head_cmd
);
   import mcf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head_cmd  = mem_ff[rd_ptr_ff];

endmodule

>>> src/mcf_back.sv
// Back end: walks a queued command and emits its frame one byte per cycle
module mcf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             not_empty,
   input  mcf_pkg::cmd_type head_cmd,
   output logic             pop,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_last
);
   import mcf_pkg::*;

   function automatic logic [BYTE_INDEX_WIDTH-1:0] last_index(input op_type op);
      case (op)
         OP_VELOCITY: last_index = BYTE_INDEX_WIDTH'(17);
         OP_STOP:     last_index = BYTE_INDEX_WIDTH'(7);
         OP_RESET:    last_index = BYTE_INDEX_WIDTH'(8);
         OP_INIT:     last_index = BYTE_INDEX_WIDTH'(6);
         default:     last_index = BYTE_INDEX_WIDTH'(6);
      endcase
   endfunction

   function automatic logic [7:0] digit(input logic [3:0] d);
      digit = 8'h30 + {4'd0, d};
   endfunction

   function automatic logic [7:0] sign_char(input logic neg);
      sign_char = neg ? "B" : "F";
   endfunction

   function automatic logic [7:0] frame_byte(input cmd_type c,
                                             input logic [BYTE_INDEX_WIDTH-1:0] idx);
      logic [7:0] b;
      begin
         b = ASCII_ETX;
         case (c.op)
            OP_VELOCITY: begin
               case (idx)
                  5'd0, 5'd9:   b = ASCII_STX;
                  5'd1, 5'd10:  b = "C";
                  5'd2, 5'd11:  b = "V";
                  5'd3:         b = "L";
                  5'd4:         b = sign_char(c.left_neg);
                  5'd5:         b = digit(c.left_d2);
                  5'd6:         b = digit(c.left_d1);
                  5'd7:         b = digit(c.left_d0);
                  5'd12:        b = "R";
                  5'd13:        b = sign_char(c.right_neg);
                  5'd14:        b = digit(c.right_d2);
                  5'd15:        b = digit(c.right_d1);
                  5'd16:        b = digit(c.right_d0);
                  default:      b = ASCII_ETX;
               endcase
            end
            OP_STOP: begin
               case (idx)
                  5'd0:    b = ASCII_STX;
                  5'd1:    b = "C";
                  5'd2:    b = "S";
                  5'd3:    b = "T";
                  5'd4:    b = "O";
                  5'd5:    b = "P";
                  5'd6:    b = 8'h30 + {6'd0, c.mode};
                  default: b = ASCII_ETX;
               endcase
            end
            OP_RESET: begin
               case (idx)
                  5'd0:       b = ASCII_STX;
                  5'd1:       b = "C";
                  5'd2:       b = "R";
                  5'd3, 5'd5: b = "E";
                  5'd4:       b = "S";
                  5'd6:       b = "T";
                  5'd7:       b = "A";
                  default:    b = ASCII_ETX;
               endcase
            end
            OP_INIT: begin
               case (idx)
                  5'd0:       b = ASCII_STX;
                  5'd1:       b = "C";
                  5'd2, 5'd4: b = "I";
                  5'd3:       b = "N";
                  5'd5:       b = "T";
                  default:    b = ASCII_ETX;
               endcase
            end
            default: b = ASCII_ETX;
         endcase
         frame_byte = b;
      end
   endfunction

   cmd_type                     cur_ff, cur_in;
   logic                        active_ff, active_in;
   logic [BYTE_INDEX_WIDTH-1:0] idx_ff, idx_in;
   logic                        last_byte;
   logic                        strobe_ff;
   logic [7:0]                  byte_ff;
   logic                        last_ff;

   assign last_byte = active_ff && (idx_ff == last_index(cur_ff.op));
   assign pop       = not_empty && (!active_ff || last_byte);

   always_comb begin
      cur_in    = cur_ff;
      active_in = active_ff;
      idx_in    = idx_ff;
      if (pop) begin
         cur_in    = head_cmd;
         active_in = 1'b1;
         idx_in    = '0;
      end else if (last_byte) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         idx_in = idx_ff + BYTE_INDEX_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      idx_ff  <= idx_in;
      byte_ff <= frame_byte(cur_ff, idx_ff);
      last_ff <= last_byte;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_tx_byte = byte_ff;
   assign rsp_last    = strobe_ff && last_ff;

endmodule

>>> src/motor_command_framer_core.sv
// Top level of the motor command framer: front end, command queue and byte sequencer
//
//   channel  | ports                                         | handshake
//   ---------+-----------------------------------------------+----------------------
//   request  | req_operation, req_left_speed/right_speed,    | start && !busy
//            | req_stop_mode                                 |
//   response | rsp_tx_byte, rsp_last                         | rsp_strobe, one cycle
//
// One byte leaves per cycle: velocity 18 beats, stop 8, reset 9, init 7.
// The byte sequencer sets the rate; back-to-back requests give gapless beats.
// When idle, the first beat follows accept via stages A, B, queue and sequencer regs.
// busy rises once QUEUE_DEPTH requests are in flight or queued.
// reset is synchronous and empties the queue and the sequencer.
// rsp_strobe marks each beat; the receiver cannot stall.
module motor_command_framer_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic signed [15:0] req_left_speed,
   input  logic signed [15:0] req_right_speed,
   input  logic [1:0]         req_stop_mode,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_tx_byte,
   output logic               rsp_last
);
   import mcf_pkg::*;

   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    not_empty;
   cmd_type head_cmd;

   mcf_front #(
      .DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_left_speed  (req_left_speed),
      .req_right_speed (req_right_speed),
      .req_stop_mode   (req_stop_mode),
      .pop             (pop),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   mcf_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .not_empty (not_empty),
      .head_cmd  (head_cmd)
   );

   mcf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .not_empty   (not_empty),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_last    (rsp_last)
   );

`include "motor_command_framer_core_assert.svh"

   `MCF_ASSERT_NOW(a_last_is_etx, rsp_last, rsp_strobe && rsp_tx_byte == ASCII_ETX,
      "final beat is not ETX")
   `MCF_ASSERT_NOW(a_first_is_stx, $rose(rsp_strobe), rsp_tx_byte == ASCII_STX,
      "first beat of a burst is not STX")
   `MCF_ASSERT_NOW(a_pop_has_data, pop, not_empty, "sequencer took from an empty queue")
   `MCF_ASSERT_NEXT(a_last_then_stx, rsp_last && rsp_strobe,
      !rsp_strobe || rsp_tx_byte == ASCII_STX, "request following a final beat lacks STX")

endmodule

>>> dv/tb_motor_command_framer_core.sv
// Self-checking testbench for motor_command_framer_core: predicts and checks every beat
`timescale 1ns / 1ps

module tb_motor_command_framer_core;
   import mcf_pkg::*;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } frame_beat_type;

   localparam int          WATCHDOG_LIMIT = 1000;
   localparam logic [7:0]  CHAR_ZERO      = "0";
   localparam logic [7:0]  CHAR_FWD       = "F";
   localparam logic [7:0]  CHAR_BACK      = "B";
   localparam logic [7:0]  CHAR_LEFT      = "L";
   localparam logic [7:0]  CHAR_RIGHT     = "R";
   localparam int          SPEED_MAX      = 999;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_operation;
   logic signed [15:0] req_left_speed;
   logic signed [15:0] req_right_speed;
   logic [1:0]         req_stop_mode;
   logic               rsp_strobe;
   logic [7:0]         rsp_tx_byte;
   logic               rsp_last;

   frame_beat_type pending_beats[$];
   frame_beat_type beat_want;
   int             error_count;
   int             quiet_cycles;
   bit             steady_run;

   motor_command_framer_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_left_speed  (req_left_speed),
      .req_right_speed (req_right_speed),
      .req_stop_mode   (req_stop_mode),
      .rsp_strobe      (rsp_strobe),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last        (rsp_last)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic void add_beat(input logic [7:0] value);
      pending_beats.push_back('{tx_byte: value, last: 1'b0});
   endfunction

   function automatic void add_text(input string text);
      foreach (text[i]) add_beat(text[i]);
   endfunction

   function automatic void add_wheel_frame(input logic [7:0] side,
                                           input logic signed [15:0] speed);
      int value;
      int mag;
      value = speed;
      if (value < -SPEED_MAX) value = -SPEED_MAX;
      if (value > SPEED_MAX) value = SPEED_MAX;
      mag = (value < 0) ? -value : value;
      add_beat(ASCII_STX);
      add_text("CV");
      add_beat(side);
      add_beat((value >= 0) ? CHAR_FWD : CHAR_BACK);
      add_beat(CHAR_ZERO + 8'((mag / 100) % 10));
      add_beat(CHAR_ZERO + 8'((mag / 10) % 10));
      add_beat(CHAR_ZERO + 8'(mag % 10));
      add_beat(ASCII_ETX);
   endfunction

   function automatic void predict_command_text(input op_type op,
                                                input logic signed [15:0] left_speed,
                                                input logic signed [15:0] right_speed,
                                                input logic [1:0] stop_mode);
      logic [1:0] mode;
      case (op)
         OP_VELOCITY: begin
            add_wheel_frame(CHAR_LEFT, left_speed);
            add_wheel_frame(CHAR_RIGHT, right_speed);
         end
         OP_STOP: begin
            mode = (stop_mode == 2'd0) ? 2'd1 : stop_mode;
            add_beat(ASCII_STX);
            add_text("CSTOP");
            add_beat(CHAR_ZERO + 8'(mode));
            add_beat(ASCII_ETX);
         end
         OP_RESET: begin
            add_beat(ASCII_STX);
            add_text("CRESETA");
            add_beat(ASCII_ETX);
         end
         default: begin
            add_beat(ASCII_STX);
            add_text("CINIT");
            add_beat(ASCII_ETX);
         end
      endcase
      pending_beats[pending_beats.size() - 1].last = 1'b1;
   endfunction

   task automatic send_command(input op_type op,
                               input logic signed [15:0] left_speed,
                               input logic signed [15:0] right_speed,
                               input logic [1:0] stop_mode);
      while (!steady_run && $urandom_range(0, 99) < 7) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start           <= 1'b1;
      req_operation   <= op;
      req_left_speed  <= left_speed;
      req_right_speed <= right_speed;
      req_stop_mode   <= stop_mode;
      do @(posedge clock); while (busy);
      predict_command_text(op, left_speed, right_speed, stop_mode);
   endtask

   function automatic logic signed [15:0] random_speed();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 1998)) - 999);
         2: return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(990, 1010))
                                              : -16'($urandom_range(990, 1010));
         default: return 16'($signed($urandom_range(0, 40)) - 20);
      endcase
   endfunction

   task automatic test_velocity_edges();
      send_command(OP_VELOCITY, 16'sd0, 16'sd0, 2'd0);
      send_command(OP_VELOCITY, 16'sd999, -16'sd999, 2'd3);
      send_command(OP_VELOCITY, -16'sd999, 16'sd999, 2'd1);
      send_command(OP_VELOCITY, 16'sd1000, -16'sd1000, 2'd2);
      send_command(OP_VELOCITY, 16'sh7FFF, 16'sh8000, 2'd0);
      send_command(OP_VELOCITY, 16'sh8000, 16'sh7FFF, 2'd3);
      send_command(OP_VELOCITY, -16'sd1, 16'sd1, 2'd0);
      send_command(OP_VELOCITY, 16'sd5, -16'sd42, 2'd0);
      send_command(OP_VELOCITY, 16'sd123, -16'sd456, 2'd0);
      send_command(OP_VELOCITY, 16'sh5555, 16'shAAAA, 2'd0);
   endtask

   task automatic test_stop_modes();
      for (int m = 0; m < 4; m++) send_command(OP_STOP, random_speed(), random_speed(), 2'(m));
   endtask

   task automatic test_reset_and_init();
      send_command(OP_RESET, 16'sh7FFF, 16'sh8000, 2'd3);
      send_command(OP_RESET, 16'sh8000, 16'sh7FFF, 2'd0);
      send_command(OP_INIT, 16'shFFFF, 16'sh0000, 2'd2);
      send_command(OP_INIT, 16'sh0000, 16'shFFFF, 2'd1);
   endtask

   task automatic test_random_mix(input int count);
      for (int i = 0; i < count; i++) begin
         steady_run = (i >= count / 3) && (i < count / 2);
         send_command(op_type'($urandom_range(0, 3)), random_speed(), random_speed(),
                      2'($urandom_range(0, 3)));
      end
      steady_run = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat %h last %b", rsp_tx_byte, rsp_last));
         end else begin
            beat_want = pending_beats.pop_front();
            if (rsp_tx_byte !== beat_want.tx_byte)
               report_mismatch($sformatf("tx_byte %h, want %h", rsp_tx_byte, beat_want.tx_byte));
            if (rsp_last !== beat_want.last)
               report_mismatch($sformatf("last %b, want %b on byte %h",
                                         rsp_last, beat_want.last, beat_want.tx_byte));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[motor_command_framer_core] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      error_count     = 0;
      quiet_cycles    = 0;
      steady_run      = 1'b0;
      reset           = 1'b1;
      start           = 1'b0;
      req_operation   = OP_VELOCITY;
      req_left_speed  = '0;
      req_right_speed = '0;
      req_stop_mode   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_velocity_edges();
      test_stop_modes();
      test_reset_and_init();
      test_random_mix(192);

      @(negedge clock);
      start <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("[motor_command_framer_core] OK");
      else
         $display("[motor_command_framer_core] ERROR");
      $finish;
   end

endmodule
